// ===== rtl/assert_macros.svh =====
// Assertion macros for the asserting RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/wlts_pkg.sv =====
// Types, constants and helpers of the windowed luma threshold selector.
package wlts_pkg;

	localparam int MAX_FRAME_DIM   = 4096;
	localparam int COUNT_BITS      = 24;
	localparam int LUMA_FULL_SCALE = 255;
	localparam int CONVERGE_EPS    = 66;
	localparam int MAX_ITERATIONS  = 16;

	localparam int Q16_ONE    = 65536;
	localparam int LUMA_W     = 8;
	localparam int HIST_DEPTH = 256;
	localparam int HIST_AW    = 8;
	localparam int DIM_W      = 13;
	localparam int POS_W      = 12;
	localparam int THR_W      = 17;
	localparam int ITER_W     = 5;
	localparam int REG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;
	localparam int SEQ_W      = 9;
	localparam int BIN_CNT_W  = 32;
	localparam int BIN_SUM_W  = 40;
	localparam int DVD_W      = BIN_SUM_W;
	localparam int DVS_W      = BIN_CNT_W;

	// divide by 255 as multiply by ceil(2^34 / 255), exact below 2^26
	localparam int          RCP_P_W = 53;
	localparam int          RCP_SH  = 34;
	localparam logic [26:0] RCP_MUL = 27'd67372037;

	localparam logic [SEQ_W-1:0] CLR_LAST = SEQ_W'(HIST_DEPTH - 1);
	localparam logic [SEQ_W-1:0] SWP_END  = SEQ_W'(HIST_DEPTH + 2);

	localparam logic [REG_IDX_W-1:0] REG_MODE  = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAC  = 4'd1;
	localparam logic [REG_IDX_W-1:0] REG_FW    = 4'd2;
	localparam logic [REG_IDX_W-1:0] REG_FH    = 4'd3;
	localparam logic [REG_IDX_W-1:0] REG_WL    = 4'd4;
	localparam logic [REG_IDX_W-1:0] REG_WT    = 4'd5;
	localparam logic [REG_IDX_W-1:0] REG_WW    = 4'd6;
	localparam logic [REG_IDX_W-1:0] REG_WH    = 4'd7;

	localparam logic [1:0] MODE_ABS    = 2'd0;
	localparam logic [1:0] MODE_MINMAX = 2'd1;
	localparam logic [1:0] MODE_ISO    = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_RUN, ST_FLUSH, ST_PREP, ST_MM, ST_SWEEP,
		ST_EVAL, ST_DD, ST_DL, ST_DN, ST_EMIT
	} state_t;

	typedef struct packed {
		logic               inc_vld;
		logic [HIST_AW-1:0] inc_addr;
		logic               swp_rd;
		logic [HIST_AW-1:0] swp_addr;
		logic               clr_wr;
		logic [HIST_AW-1:0] clr_addr;
	} hist_cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] lo;
		logic [DIM_W-1:0] hi;
	} span_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_FRAME_DIM))
			r = DIM_W'(MAX_FRAME_DIM);
		else
			r = v;
		return r;
	endfunction

	function automatic span_t win_span(input logic [DIM_W-1:0] frame,
		input logic [POS_W-1:0] start, input logic [DIM_W-1:0] size);
		logic [DIM_W-1:0] sz;
		logic [DIM_W-1:0] st;
		logic [DIM_W:0]   endp;
		span_t            s;
		sz   = (size == '0 || size > frame) ? frame : size;
		endp = (DIM_W+1)'(start) + (DIM_W+1)'(sz);
		st   = (endp > (DIM_W+1)'(frame)) ? frame - sz : DIM_W'(start);
		s.lo = st;
		s.hi = st + sz;
		return s;
	endfunction

endpackage

// ===== rtl/wlts_if.sv =====
// Stream and configuration interfaces of the threshold selector.
interface wlts_pix_if;
	logic                       valid;
	logic                       ready;
	logic [wlts_pkg::LUMA_W-1:0] luma;
	logic                       frame_end;
	modport source(output valid, luma, frame_end, input ready);
	modport sink(input valid, luma, frame_end, output ready);
endinterface

interface wlts_res_if;
	logic                        valid;
	logic                        ready;
	logic [wlts_pkg::THR_W-1:0]  threshold_out;
	logic [wlts_pkg::LUMA_W-1:0] window_min;
	logic [wlts_pkg::LUMA_W-1:0] window_max;
	logic                        class_empty;
	logic [wlts_pkg::ITER_W-1:0] iterations_used;
	modport source(output valid, threshold_out, window_min, window_max, class_empty,
		iterations_used, input ready);
	modport sink(input valid, threshold_out, window_min, window_max, class_empty,
		iterations_used, output ready);
endinterface

interface wlts_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wlts_pkg::REG_IDX_W-1:0]  index;
	logic [wlts_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/wlts_hist.sv =====
// Luma histogram memory with read-modify-write increment and forwarding.
module wlts_hist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wlts_pkg::hist_cmd_t                 cmd,
	output logic [wlts_pkg::COUNT_BITS-1:0]     rd_data
);
	import wlts_pkg::*;

	logic [COUNT_BITS-1:0] mem [HIST_DEPTH];
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] lw_data_q;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] wd;
	logic [HIST_AW-1:0]    addr_s1;
	logic [HIST_AW-1:0]    lw_addr_q;
	logic [HIST_AW-1:0]    ra;
	logic [HIST_AW-1:0]    wa;
	logic                  inc_s1;
	logic                  lw_vld_q;
	logic                  we;

	assign ra  = cmd.inc_vld ? cmd.inc_addr : cmd.swp_addr;
	assign cur = (lw_vld_q && lw_addr_q == addr_s1) ? lw_data_q : rd_q;
	assign we  = inc_s1 || cmd.clr_wr;
	assign wa  = inc_s1 ? addr_s1 : cmd.clr_addr;
	assign wd  = inc_s1 ? ((cur == '1) ? cur : cur + 1'b1) : '0;
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (cmd.inc_vld || cmd.swp_rd)
			rd_q <= mem[ra];
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		addr_s1   <= cmd.inc_addr;
		lw_addr_q <= wa;
		lw_data_q <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s1   <= 1'b0;
			lw_vld_q <= 1'b0;
		end else begin
			inc_s1   <= cmd.inc_vld;
			lw_vld_q <= we;
		end
	end

endmodule

// ===== rtl/wlts_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wlts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wlts_pkg::DVD_W-1:0]  dividend,
	input  logic [wlts_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic                        done,
	output logic [wlts_pkg::DVD_W-1:0]  quotient
);
	import wlts_pkg::*;

	localparam int CW = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   sh;
	logic [DVS_W:0]   rem_n;
	logic             ge;

	assign sh    = {rem_q, quo_q[DVD_W-1]};
	assign ge    = sh >= {1'b0, dvs_q};
	assign rem_n = ge ? sh - {1'b0, dvs_q} : sh;

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= rem_n[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/window_luma_threshold_select.sv =====
// Top level of the windowed luma threshold selector.
//
//  channel  dir  payload                                          accepted when
//  pix      in   luma, frame_end                                  valid & ready
//  res      out  threshold_out, window_min/max, class_empty, iter valid & ready
//  cfg      in   index, data                                      valid & ready
//
// Pixels: one per cycle while a frame streams in (histogram read-modify-write).
// After frame end: mode 0 goes from flush to emit; mode 1 first passes prep and min/max
// (constant divide by multiply). Mode 2 adds per iteration a sweep, an evaluation, two
// divisions of the class sums and an estimate; it emits after evaluation if a class is
// empty. Then a histogram clearing pass over all 256 bins; the same pass runs after reset.
// pix is low from frame end to the end of clearing; a waiting result holds in its output
// register, and the next result waits in the emit state for it to leave.
module window_luma_threshold_select (
	input logic        clk,
	input logic        arst_n,
	wlts_pix_if.sink   pix,
	wlts_res_if.source res,
	wlts_cfg_if.sink   cfg
);
	import wlts_pkg::*;
	`include "assert_macros.svh"

	logic [1:0]            mode_q;
	logic [THR_W-1:0]      frac_q;
	logic [DIM_W-1:0]      fw_q, fh_q, ww_q, wh_q;
	logic [POS_W-1:0]      wl_q, wt_q;

	state_t                state_q, state_d;
	logic [SEQ_W-1:0]      cnt_q;
	logic [POS_W-1:0]      col_q, row_q;
	logic [LUMA_W-1:0]     min_q, max_q;
	logic [24:0]           prod_q;
	logic [THR_W-1:0]      start_q, t_q, thr_q;
	logic [ITER_W-1:0]     n_q;
	logic                  empty_q;
	logic [LUMA_W-1:0]     md_q;
	logic [RCP_P_W-1:0]    rcp_q;

	logic                  vld_s1, vld_s2, dark_s2;
	logic [LUMA_W-1:0]     v_s1;
	logic [COUNT_BITS-1:0] cntv_s2;
	logic [31:0]           prod_s2;
	logic [BIN_CNT_W-1:0]  cd_q, cl_q;
	logic [BIN_SUM_W-1:0]  sd_q, sl_q;

	logic                  out_vld_q;
	logic [THR_W-1:0]      out_thr_q;
	logic [LUMA_W-1:0]     out_min_q, out_max_q;
	logic                  out_empty_q;
	logic [ITER_W-1:0]     out_iter_q;

	hist_cmd_t             hcmd;
	logic [COUNT_BITS-1:0] hrd;
	logic                  div_start, div_busy, div_done;
	logic [DVD_W-1:0]      div_dvd, div_q;
	logic [DVS_W-1:0]      div_dvs;

	logic [DIM_W-1:0]      fw, fh;
	span_t                 xs, ys;
	logic                  in_win, pix_acc, emit_go, iso_stop;
	logic [THR_W-1:0]      frac_eff, nt, diff, rcp_quo;
	logic [LUMA_W-1:0]     mn, mx, rng, split;
	logic [24:0]           sp_prod;
	logic [25:0]           num;
	logic [LUMA_W:0]       msum;
	logic [24:0]           nsum;

	wlts_hist u_hist (.clk(clk), .arst_n(arst_n), .cmd(hcmd), .rd_data(hrd));

	wlts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .busy(div_busy), .done(div_done), .quotient(div_q)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MINMAX;
			frac_q <= THR_W'(32768);
			fw_q   <= DIM_W'(640);
			fh_q   <= DIM_W'(480);
			wl_q   <= '0;
			wt_q   <= '0;
			ww_q   <= '0;
			wh_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE: mode_q <= cfg.data[1:0];
				REG_FRAC: frac_q <= cfg.data;
				REG_FW:   fw_q   <= cfg.data[DIM_W-1:0];
				REG_FH:   fh_q   <= cfg.data[DIM_W-1:0];
				REG_WL:   wl_q   <= cfg.data[POS_W-1:0];
				REG_WT:   wt_q   <= cfg.data[POS_W-1:0];
				REG_WW:   ww_q   <= cfg.data[DIM_W-1:0];
				REG_WH:   wh_q   <= cfg.data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign frac_eff = (frac_q > THR_W'(Q16_ONE)) ? THR_W'(Q16_ONE) : frac_q;
	assign fw       = clamp_dim(fw_q);
	assign fh       = clamp_dim(fh_q);
	assign xs       = win_span(fw, wl_q, ww_q);
	assign ys       = win_span(fh, wt_q, wh_q);
	assign in_win   = DIM_W'(col_q) >= xs.lo && DIM_W'(col_q) < xs.hi &&
	                  DIM_W'(row_q) >= ys.lo && DIM_W'(row_q) < ys.hi;
	assign pix_acc  = pix.valid && pix.ready;

	assign mn      = (min_q > max_q) ? '0 : min_q;
	assign mx      = (min_q > max_q) ? '0 : max_q;
	assign rng     = mx - mn;
	assign num     = {2'b00, mn, 16'h0000} + 26'(prod_q) + 26'(LUMA_FULL_SCALE / 2);
	assign sp_prod = 25'(t_q) * 25'(LUMA_FULL_SCALE);
	assign split   = sp_prod[23:16];
	assign msum    = {1'b0, md_q} + {1'b0, div_q[LUMA_W-1:0]};
	assign nsum    = {msum, 16'h0000} + 25'(LUMA_FULL_SCALE);
	assign rcp_quo = rcp_q[RCP_SH +: THR_W];
	assign nt      = rcp_quo;
	assign diff    = (nt > t_q) ? nt - t_q : t_q - nt;
	assign iso_stop = diff <= THR_W'(CONVERGE_EPS) || n_q == ITER_W'(MAX_ITERATIONS);
	assign emit_go = !out_vld_q || res.ready;

	always_comb begin
		state_d   = state_q;
		hcmd      = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		pix.ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				hcmd.clr_wr   = 1'b1;
				hcmd.clr_addr = cnt_q[HIST_AW-1:0];
				if (cnt_q == CLR_LAST)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				pix.ready     = 1'b1;
				hcmd.inc_vld  = pix_acc && in_win;
				hcmd.inc_addr = pix.luma;
				if (pix_acc && pix.frame_end)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (mode_q == MODE_MINMAX || mode_q == MODE_ISO)
					state_d = ST_PREP;
				else
					state_d = ST_EMIT;
			end
			ST_PREP: begin
				state_d = ST_MM;
			end
			ST_MM: begin
				state_d = (mode_q == MODE_ISO) ? ST_SWEEP : ST_EMIT;
			end
			ST_SWEEP: begin
				hcmd.swp_rd   = cnt_q < SEQ_W'(HIST_DEPTH);
				hcmd.swp_addr = cnt_q[HIST_AW-1:0];
				if (cnt_q == SWP_END)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (cd_q == '0 || cl_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					div_start = 1'b1;
					div_dvd   = sd_q;
					div_dvs   = cd_q;
					state_d   = ST_DD;
				end
			end
			ST_DD: begin
				if (div_done) begin
					div_start = 1'b1;
					div_dvd   = sl_q;
					div_dvs   = cl_q;
					state_d   = ST_DL;
				end
			end
			ST_DL: begin
				if (div_done)
					state_d = ST_DN;
			end
			ST_DN: begin
				state_d = iso_stop ? ST_EMIT : ST_SWEEP;
			end
			ST_EMIT: begin
				if (emit_go)
					state_d = ST_CLEAR;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			min_q     <= '1;
			max_q     <= '0;
			n_q       <= '0;
			empty_q   <= 1'b0;
			out_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= state_q == ST_SWEEP && cnt_q < SEQ_W'(HIST_DEPTH);
			vld_s2  <= vld_s1;
			if (state_q == ST_EMIT && emit_go)
				out_vld_q <= 1'b1;
			else if (res.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_CLEAR: cnt_q <= (cnt_q == CLR_LAST) ? '0 : cnt_q + 1'b1;
				ST_RUN: begin
					if (pix_acc) begin
						if (in_win) begin
							if (pix.luma < min_q) min_q <= pix.luma;
							if (pix.luma > max_q) max_q <= pix.luma;
						end
						if (DIM_W'(col_q) + 1'b1 >= fw) begin
							col_q <= '0;
							row_q <= (DIM_W'(row_q) + 1'b1 >= fh) ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					n_q     <= ITER_W'(1);
					empty_q <= 1'b0;
				end
				ST_MM: cnt_q <= '0;
				ST_SWEEP: cnt_q <= cnt_q + 1'b1;
				ST_EVAL: if (cd_q == '0 || cl_q == '0) empty_q <= 1'b1;
				ST_DN: begin
					if (!iso_stop) begin
						n_q   <= n_q + 1'b1;
						cnt_q <= '0;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						min_q     <= '1;
						max_q     <= '0;
						col_q     <= '0;
						row_q     <= '0;
						cnt_q     <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		v_s1    <= cnt_q[LUMA_W-1:0];
		prod_s2 <= 32'(hrd) * 32'(v_s1);
		cntv_s2 <= hrd;
		dark_s2 <= v_s1 <= split;
		if (vld_s2) begin
			if (dark_s2) begin
				cd_q <= cd_q + BIN_CNT_W'(cntv_s2);
				sd_q <= sd_q + BIN_SUM_W'(prod_s2);
			end else begin
				cl_q <= cl_q + BIN_CNT_W'(cntv_s2);
				sl_q <= sl_q + BIN_SUM_W'(prod_s2);
			end
		end
		case (state_q)
			ST_FLUSH: begin
				prod_q <= 25'(frac_eff) * 25'(rng);
				thr_q  <= frac_eff;
			end
			ST_PREP: rcp_q <= RCP_P_W'(num) * RCP_P_W'(RCP_MUL);
			ST_MM: begin
				start_q <= rcp_quo;
				thr_q   <= rcp_quo;
				t_q     <= rcp_quo;
				cd_q    <= '0;
				cl_q    <= '0;
				sd_q    <= '0;
				sl_q    <= '0;
			end
			ST_EVAL: if (cd_q == '0 || cl_q == '0) thr_q <= start_q;
			ST_DD: if (div_done) md_q <= div_q[LUMA_W-1:0];
			// sum / 510 taken as (sum / 2) / 255
			ST_DL: if (div_done) rcp_q <= RCP_P_W'(nsum[24:1]) * RCP_P_W'(RCP_MUL);
			ST_DN: begin
				t_q   <= nt;
				thr_q <= nt;
				cd_q  <= '0;
				cl_q  <= '0;
				sd_q  <= '0;
				sl_q  <= '0;
			end
			ST_EMIT: begin
				if (emit_go) begin
					out_thr_q   <= thr_q;
					out_min_q   <= mn;
					out_max_q   <= mx;
					out_empty_q <= (mode_q == MODE_ISO) ? empty_q : 1'b0;
					out_iter_q  <= (mode_q == MODE_ISO) ? n_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign res.valid           = out_vld_q;
	assign res.threshold_out   = out_thr_q;
	assign res.window_min      = out_min_q;
	assign res.window_max      = out_max_q;
	assign res.class_empty     = out_empty_q;
	assign res.iterations_used = out_iter_q;

	`ASSERT_NEXT(a_result_held, state_q == ST_EMIT && out_vld_q && !res.ready, state_q == ST_EMIT)
	`ASSERT_IMPL(a_div_idle_start, div_start, !div_busy)
	`ASSERT_IMPL(a_iter_bound, out_vld_q, out_iter_q <= ITER_W'(MAX_ITERATIONS))
	`ASSERT_NEXT(a_sweep_end, state_q == ST_SWEEP && cnt_q == SWP_END, state_q == ST_EVAL && !vld_s2)

endmodule
